[sv/sfr_pkg.sv]
// sfr_pkg: shared types and constants for the stream find-and-replace block
// no dependencies; compiled first
package sfr_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 8'd3;

    // field widths
    localparam int BYTE_W = 8;
    localparam int TEXT_W = 64;
    localparam int LEN_W  = 4;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // one burst of output bytes, byte 0 in the low bits
    typedef struct packed {
        logic [TEXT_W-1:0] data;
        logic [LEN_W-1:0]  cnt;
        logic              last;
    } sfr_cmd_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } sfr_q_stat_t;

endpackage

[sv/sfr_if.sv]
// sfr_in_if / sfr_out_if: valid-ready stream channels for input and result bytes
// depends on: nothing
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_run_end;
    logic       out_stream_end;

    modport source (output valid, output out_byte, output out_run_end,
                    output out_stream_end, input ready);
    modport sink   (input valid, input out_byte, input out_run_end,
                    input out_stream_end, output ready);
endinterface

[sv/sfr_front.sv]
// sfr_front: config registers, byte window, match check, burst command build
// depends on: sfr_pkg, sfr_in_if
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN_LEN     = 8,
    parameter int MAX_REPLACEMENT_LEN = 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    sfr_in_if.sink                in_ch,
    input  sfr_q_stat_t           q_stat,
    output logic                  push,
    output sfr_cmd_t              push_cmd
);

    localparam int FILL_W = $clog2(MAX_PATTERN_LEN + 1);

    logic [TEXT_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0]  pattern_len_reg;
    logic [TEXT_W-1:0] replacement_bytes_reg;
    logic [LEN_W-1:0]  replacement_len_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [BYTE_W-1:0] window_reg [MAX_PATTERN_LEN];
    logic [BYTE_W-1:0] window_next [MAX_PATTERN_LEN];
    logic [BYTE_W-1:0] win_cur [MAX_PATTERN_LEN];

    logic              in_xfer;
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  fill_eff;
    logic [LEN_W-1:0]  fill_new;
    logic              full;
    logic              all_eq;
    logic              matched;
    logic [TEXT_W-1:0] flush_data;

    assign in_ch.ready = !q_stat.full;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    // saturated lengths
    assign plen = (pattern_len_reg > LEN_W'(MAX_PATTERN_LEN)) ?
                  LEN_W'(MAX_PATTERN_LEN) : pattern_len_reg;
    assign rlen = (replacement_len_reg > LEN_W'(MAX_REPLACEMENT_LEN)) ?
                  LEN_W'(MAX_REPLACEMENT_LEN) : replacement_len_reg;

    // window with the new byte written at the fill position
    assign fill_eff = (LEN_W'(fill_reg) >= plen) ? '0 : LEN_W'(fill_reg);
    assign fill_new = fill_eff + LEN_W'(1);
    assign full     = (fill_new == plen);

    always_comb
    begin
        all_eq     = 1'b1;
        flush_data = '0;
        for (int k = 0; k < MAX_PATTERN_LEN; k++)
        begin
            win_cur[k] = (LEN_W'(k) == fill_eff) ? in_ch.in_byte : window_reg[k];
            flush_data[BYTE_W*k +: BYTE_W] = win_cur[k];
            if ((LEN_W'(k) < plen) && (win_cur[k] != pattern_bytes_reg[BYTE_W*k +: BYTE_W]))
            begin
                all_eq = 1'b0;
            end
        end
    end

    assign matched = full && all_eq;

    // classify the byte into a burst command
    always_comb
    begin
        push_cmd.data = {{(TEXT_W-BYTE_W){1'b0}}, in_ch.in_byte};
        push_cmd.cnt  = '0;
        push_cmd.last = in_ch.in_last;
        if (plen == '0)
        begin
            push_cmd.cnt = LEN_W'(1);
        end
        else if (matched)
        begin
            push_cmd.data = replacement_bytes_reg;
            push_cmd.cnt  = rlen;
        end
        else if (in_ch.in_last)
        begin
            push_cmd.data = flush_data;
            push_cmd.cnt  = fill_new;
        end
        else if (full)
        begin
            push_cmd.data = {{(TEXT_W-BYTE_W){1'b0}}, win_cur[0]};
            push_cmd.cnt  = LEN_W'(1);
        end
    end

    assign push = in_xfer && (push_cmd.cnt != '0);

    // window update: clear on a match or the last byte, slide on a full mismatch, else keep the written byte
    always_comb
    begin
        fill_next = fill_reg;
        for (int k = 0; k < MAX_PATTERN_LEN; k++)
        begin
            window_next[k] = window_reg[k];
        end
        if (in_xfer && (plen != '0))
        begin
            if (matched || in_ch.in_last)
            begin
                fill_next = '0;
            end
            else if (full)
            begin
                for (int k = 0; k < MAX_PATTERN_LEN - 1; k++)
                begin
                    window_next[k] = win_cur[k+1];
                end
                fill_next = FILL_W'(fill_eff);
            end
            else
            begin
                for (int k = 0; k < MAX_PATTERN_LEN; k++)
                begin
                    window_next[k] = win_cur[k];
                end
                fill_next = FILL_W'(fill_new);
            end
        end
        // a pattern length write drops the held bytes
        if (cfg_we && (cfg_index == REG_PATTERN_LEN))
        begin
            fill_next = '0;
        end
    end

    // window bytes
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PATTERN_LEN; k++)
        begin
            window_reg[k] <= window_next[k];
        end
    end

    // config registers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg     <= '0;
            pattern_len_reg       <= '0;
            replacement_bytes_reg <= '0;
            replacement_len_reg   <= '0;
            fill_reg              <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PATTERN_BYTES:     pattern_bytes_reg <= cfg_wdata;
                    REG_PATTERN_LEN:       pattern_len_reg <= cfg_wdata[LEN_W-1:0];
                    REG_REPLACEMENT_BYTES: replacement_bytes_reg <= cfg_wdata;
                    REG_REPLACEMENT_LEN:   replacement_len_reg <= cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[sv/sfr_queue.sv]
// sfr_queue: short command queue between the front and the back
// depends on: sfr_pkg
module sfr_queue
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sfr_cmd_t    push_cmd,
    input  logic        pop,
    output sfr_cmd_t    head_cmd,
    output sfr_q_stat_t q_stat
);

    sfr_cmd_t           entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign head_cmd         = entry_reg[rd_ptr_reg];
    assign q_stat.full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.not_empty = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[sv/sfr_back.sv]
// sfr_back: expands burst commands into output bytes through an output register
// depends on: sfr_pkg, sfr_out_if
module sfr_back
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sfr_cmd_t    head_cmd,
    input  sfr_q_stat_t q_stat,
    output logic        pop,
    sfr_out_if.source   out_ch
);

    logic              active_reg;
    logic              active_next;
    logic [TEXT_W-1:0] data_reg;
    logic [TEXT_W-1:0] data_next;
    logic [LEN_W-1:0]  remain_reg;
    logic [LEN_W-1:0]  remain_next;
    logic              last_reg;
    logic              last_next;
    logic              out_xfer;
    logic              final_byte;

    assign final_byte = (remain_reg == LEN_W'(1));
    assign out_xfer   = out_ch.valid && out_ch.ready;

    assign out_ch.valid          = active_reg;
    assign out_ch.out_byte       = data_reg[BYTE_W-1:0];
    assign out_ch.out_run_end    = final_byte;
    assign out_ch.out_stream_end = final_byte && last_reg;

    // take the next command when idle or on the final byte of a burst
    assign pop = q_stat.not_empty && (!active_reg || (out_xfer && final_byte));

    always_comb
    begin
        active_next = active_reg;
        data_next   = data_reg;
        remain_next = remain_reg;
        last_next   = last_reg;
        if (pop)
        begin
            active_next = 1'b1;
            data_next   = head_cmd.data;
            remain_next = head_cmd.cnt;
            last_next   = head_cmd.last;
        end
        else if (out_xfer)
        begin
            if (final_byte)
            begin
                active_next = 1'b0;
            end
            else
            begin
                data_next   = data_reg >> BYTE_W;
                remain_next = remain_reg - LEN_W'(1);
            end
        end
    end

    // burst payload
    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        remain_reg <= remain_next;
        last_reg   <= last_next;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

[sv/stream_find_and_replace.sv]
// stream_find_and_replace: top level, front classifier, command queue, back expander
// depends on: sfr_pkg, sfr_if, sfr_front, sfr_queue, sfr_back
//
// channel   dir  handshake     payload
// in_ch     in   valid/ready   in_byte[7:0], in_last
// out_ch    out  valid/ready   out_byte[7:0], out_run_end, out_stream_end
// cfg       in   cfg_we only   cfg_index[7:0], cfg_wdata[63:0]
//
// one input byte per cycle while in_ch is ready; each byte is classified
// in its transfer cycle; an input byte yields 0 to 8 result bytes, which
// leave at one byte per cycle while out_ch is ready
// a result passes through a queue entry and then the output register
// reset clears config, window fill, queue pointers and output valid
// in_ch stalls only while the four-entry command queue is full
module stream_find_and_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN_LEN     = 8,
    parameter int MAX_REPLACEMENT_LEN = 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    sfr_in_if.sink                in_ch,
    sfr_out_if.source             out_ch
);

    logic        push;
    logic        pop;
    sfr_cmd_t    push_cmd;
    sfr_cmd_t    head_cmd;
    sfr_q_stat_t q_stat;

    // classify input bytes
    sfr_front #(
        .MAX_PATTERN_LEN     (MAX_PATTERN_LEN),
        .MAX_REPLACEMENT_LEN (MAX_REPLACEMENT_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // decouple front and back
    sfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // emit result bytes
    sfr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

[sv/sfr_checker.sv]
// sfr_checker: port-level assertions for stream_find_and_replace
// depends on: stream_find_and_replace (bound to its ports)
module sfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_run_end,
    input logic       out_stream_end
);

    // stream end only on the last result of a run
    a_stream_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stream_end |-> out_run_end)
        else $error("stream end without run end");

    // no result shown while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // queue empty right after reset, input open
    a_ready_after_reset: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> in_ready)
        else $error("input not ready after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(out_run_end) && $stable(out_stream_end))
        else $error("stalled result changed");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_run_end    (out_ch.out_run_end),
    .out_stream_end (out_ch.out_stream_end)
);
